// File: design/nmc_pkg.sv
// Shared types and constants for the NMEA sentence checker.
// No dependencies; the parser, the output stage and the top level import this package.
package nmc_pkg;

  // ASCII codes the parser reacts to
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_F      = 8'h46;

  // Talker/sentence headers, five bytes after the dollar sign
  localparam logic [39:0] HDR_RMC = 40'h4750524D43;
  localparam logic [39:0] HDR_GGA = 40'h4750474741;
  localparam logic [39:0] HDR_VTG = 40'h4750565447;
  localparam logic [39:0] HDR_GSA = 40'h4750475341;

  // Result status codes
  localparam logic [1:0] ST_MATCH    = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Sentence kind codes
  localparam logic [2:0] KIND_OTHER = 3'd0;
  localparam logic [2:0] KIND_RMC   = 3'd1;
  localparam logic [2:0] KIND_GGA   = 3'd2;
  localparam logic [2:0] KIND_VTG   = 3'd3;
  localparam logic [2:0] KIND_GSA   = 3'd4;

  // Header occupies byte positions 1..5, classified once position 6 is reached
  localparam logic [6:0] HDR_FIRST_POS = 7'd1;
  localparam logic [6:0] HDR_LAST_POS  = 7'd5;
  localparam logic [6:0] HDR_DONE_POS  = 7'd6;

  // Comma index of the fix-status field per sentence kind
  localparam logic [3:0] RMC_FIX_FIELD = 4'd2;
  localparam logic [3:0] GGA_FIX_FIELD = 4'd6;
  localparam logic [3:0] GSA_FIX_FIELD = 4'd2;
  localparam logic [3:0] COMMA_MAX     = 4'd15;
  localparam logic [1:0] DIGITS_FULL   = 2'd2;

  // One finished-sentence result word
  typedef struct packed {
    logic [1:0] status;
    logic [2:0] sentence_kind;
    logic       fix_valid;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic [6:0] sentence_length;
  } nmc_result_t;

  // Upper-case hex digit decode: {bad, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      r = {1'b0, 4'(b - CH_ZERO)};
    end else if (b >= CH_A && b <= CH_F) begin
      r = {1'b0, 4'(b - CH_A + 8'd10)};
    end else begin
      r = {1'b1, 4'd0};
    end
    return r;
  endfunction

endpackage

// File: design/nmc_in_stage.sv
// Input register of the sentence checker: holds one received byte word.
// Depends on nothing but the handshake from the downstream stage.
module nmc_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       advance,
  output logic       fire,
  output logic [7:0] byte_q
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r,  byte_nxt;

  // accept a new word whenever the held one is empty or moving on
  assign in_ready = !valid_r || advance;
  assign fire     = valid_r && advance;
  assign byte_q   = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
      byte_nxt  = in_rx_byte;
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    byte_r <= byte_nxt;
  end

endmodule

// File: design/nmc_parser.sv
// Sentence framing, checksum, header classification and fix tracking.
// Depends on nmc_pkg; processes one byte per fire, result is combinational.
module nmc_parser #(
  parameter int MAX_LEN = 100
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          rx_byte,
  output logic                res_valid,
  output nmc_pkg::nmc_result_t res
);
  import nmc_pkg::*;

  localparam logic [6:0] LEN_LIMIT = 7'(MAX_LEN - 1);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_BODY   = 3'b010,
    PH_DIGITS = 3'b100
  } phase_t;

  phase_t      phase_r,   phase_nxt;
  logic [7:0]  xor_r,     xor_nxt;
  logic [7:0]  dsum_r,    dsum_nxt;
  logic [1:0]  dcnt_r,    dcnt_nxt;
  logic        dbad_r,    dbad_nxt;
  logic [6:0]  bcnt_r,    bcnt_nxt;
  logic [39:0] hdr_r,     hdr_nxt;
  logic [2:0]  kind_r,    kind_nxt;
  logic [3:0]  comma_r,   comma_nxt;
  logic        fix_r,     fix_nxt;
  logic        fstart_r,  fstart_nxt;
  logic [1:0]  st;
  logic [4:0]  hex;

  assign hex = hex_decode(rx_byte);

  always_comb begin
    phase_nxt  = phase_r;
    xor_nxt    = xor_r;
    dsum_nxt   = dsum_r;
    dcnt_nxt   = dcnt_r;
    dbad_nxt   = dbad_r;
    bcnt_nxt   = bcnt_r;
    hdr_nxt    = hdr_r;
    kind_nxt   = kind_r;
    comma_nxt  = comma_r;
    fix_nxt    = fix_r;
    fstart_nxt = fstart_r;
    res_valid  = 1'b0;
    st         = ST_MISMATCH;

    if (fire) begin
      unique case (phase_r)
        // wait for the start of a sentence
        PH_IDLE: begin
          if (rx_byte == CH_DOLLAR) begin
            xor_nxt    = '0;
            dsum_nxt   = '0;
            dcnt_nxt   = '0;
            dbad_nxt   = 1'b0;
            bcnt_nxt   = 7'd1;
            hdr_nxt    = '0;
            kind_nxt   = KIND_OTHER;
            comma_nxt  = '0;
            fix_nxt    = 1'b0;
            fstart_nxt = 1'b1;
            phase_nxt  = PH_BODY;
          end
        end
        PH_BODY, PH_DIGITS: begin
          // header capture and classification
          if (bcnt_r >= HDR_FIRST_POS && bcnt_r <= HDR_LAST_POS) begin
            hdr_nxt = {hdr_r[31:0], rx_byte};
          end
          bcnt_nxt = bcnt_r + 7'd1;
          if (bcnt_nxt == HDR_DONE_POS) begin
            if (hdr_nxt == HDR_RMC)      kind_nxt = KIND_RMC;
            else if (hdr_nxt == HDR_GGA) kind_nxt = KIND_GGA;
            else if (hdr_nxt == HDR_VTG) kind_nxt = KIND_VTG;
            else if (hdr_nxt == HDR_GSA) kind_nxt = KIND_GSA;
            else                         kind_nxt = KIND_OTHER;
          end

          if (rx_byte == CH_LF) begin
            // end of sentence: compare checksums
            if (phase_r == PH_DIGITS && dcnt_r == DIGITS_FULL && !dbad_r &&
                dsum_r == xor_r) begin
              st = ST_MATCH;
            end
            res_valid = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            if (phase_r == PH_BODY) begin
              if (rx_byte == CH_STAR) begin
                phase_nxt = PH_DIGITS;
              end else begin
                xor_nxt = xor_r ^ rx_byte;
                if (rx_byte == CH_COMMA) begin
                  if (comma_r < COMMA_MAX) comma_nxt = comma_r + 4'd1;
                  fstart_nxt = 1'b0;
                end else if (!fstart_r) begin
                  // first character of a field: fix status check
                  fstart_nxt = 1'b1;
                  if (kind_nxt == KIND_RMC && comma_r == RMC_FIX_FIELD) begin
                    fix_nxt = (rx_byte == CH_A);
                  end else if (kind_nxt == KIND_GGA && comma_r == GGA_FIX_FIELD) begin
                    fix_nxt = (rx_byte != CH_ZERO);
                  end else if (kind_nxt == KIND_GSA && comma_r == GSA_FIX_FIELD) begin
                    fix_nxt = (rx_byte != CH_ZERO);
                  end
                end
              end
            end else if (dcnt_r < DIGITS_FULL) begin
              // checksum digits after the asterisk
              if (hex[4]) dbad_nxt = 1'b1;
              dsum_nxt = {dsum_r[3:0], hex[3:0]};
              dcnt_nxt = dcnt_r + 2'd1;
            end

            // length overflow
            if (bcnt_nxt >= LEN_LIMIT) begin
              st        = ST_OVERFLOW;
              res_valid = 1'b1;
              phase_nxt = PH_IDLE;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  assign res.status          = st;
  assign res.sentence_kind   = kind_nxt;
  assign res.fix_valid       = fix_nxt;
  assign res.computed_sum    = xor_nxt;
  assign res.received_sum    = dsum_nxt;
  assign res.sentence_length = bcnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      xor_r    <= '0;
      dsum_r   <= '0;
      dcnt_r   <= '0;
      dbad_r   <= 1'b0;
      bcnt_r   <= '0;
      hdr_r    <= '0;
      kind_r   <= KIND_OTHER;
      comma_r  <= '0;
      fix_r    <= 1'b0;
      fstart_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      xor_r    <= xor_nxt;
      dsum_r   <= dsum_nxt;
      dcnt_r   <= dcnt_nxt;
      dbad_r   <= dbad_nxt;
      bcnt_r   <= bcnt_nxt;
      hdr_r    <= hdr_nxt;
      kind_r   <= kind_nxt;
      comma_r  <= comma_nxt;
      fix_r    <= fix_nxt;
      fstart_r <= fstart_nxt;
    end
  end

endmodule

// File: design/nmc_out_stage.sv
// Result register of the sentence checker with valid/ready output.
// Depends on nmc_pkg for the result word type.
module nmc_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  nmc_pkg::nmc_result_t res_in,
  output logic                 space,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nmc_pkg::nmc_result_t res_q
);
  import nmc_pkg::*;

  logic        valid_r, valid_nxt;
  nmc_result_t data_r,  data_nxt;

  // room for a new result when empty or being drained this cycle
  assign space     = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_q     = data_r;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = res_in;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

endmodule

// File: design/nmea_sentence_checker.sv
//  channel | ports                                   | dir | role
//  --------+-----------------------------------------+-----+---------------------------
//  in      | in_valid, in_ready, in_rx_byte          | in  | one serial byte per word
//  out     | out_valid, out_ready, out_status ...    | out | one word per sentence end
//
// One byte word per cycle is taken while the output is not stalled; the result for the byte
// that ends or overflows a sentence passes through the input register, then the parse step
// and the result register, and is then presented on the out channel with out_valid.
// The rate is set by the combinational parse step between those registers.
// Reset (rst_n low, synchronous) empties both registers and returns the parser
// to waiting for a dollar sign. A stalled output holds the parse step, and
// the input register then fills and drops in_ready.
module nmea_sentence_checker #(
  parameter int MAX_LEN = 100
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [2:0] out_sentence_kind,
  output logic       out_fix_valid,
  output logic [7:0] out_computed_sum,
  output logic [7:0] out_received_sum,
  output logic [6:0] out_sentence_length
);
  import nmc_pkg::*;

  logic        fire;
  logic        space;
  logic [7:0]  byte_q;
  logic        res_valid;
  nmc_result_t res;
  nmc_result_t res_q;

  // input register
  nmc_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_rx_byte(in_rx_byte),
    .advance   (space),
    .fire      (fire),
    .byte_q    (byte_q)
  );

  // parse step
  nmc_parser #(
    .MAX_LEN(MAX_LEN)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .rx_byte  (byte_q),
    .res_valid(res_valid),
    .res      (res)
  );

  // result register
  nmc_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (res_valid),
    .res_in   (res),
    .space    (space),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .res_q    (res_q)
  );

  assign out_status          = res_q.status;
  assign out_sentence_kind   = res_q.sentence_kind;
  assign out_fix_valid       = res_q.fix_valid;
  assign out_computed_sum    = res_q.computed_sum;
  assign out_received_sum    = res_q.received_sum;
  assign out_sentence_length = res_q.sentence_length;

endmodule
